>>> hdl/ghash_pkg.sv
`timescale 1ns / 1ps
// ghash_pkg: shared types, codes and constants of the ghash accumulator
package ghash_pkg;

    localparam int BLOCK_W       = 128;
    localparam int HALF_W        = 64;
    localparam int COUNT_W       = 61;
    localparam int VBYTES_W      = 5;
    localparam int BITS_PER_STEP = 8;
    localparam int MUL_STEPS     = BLOCK_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(MUL_STEPS);
    localparam int CFG_INDEX_W   = 1;
    localparam int BLOCK_BYTES   = BLOCK_W / 8;

    localparam logic [7:0] REDUCE_BYTE = 8'hE1;

    // request codes
    localparam logic [1:0] REQ_AAD    = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HI = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LO = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // absorb the request into x, start a multiply
        logic finish;   // load the length block and clear the counters
        logic aad;      // byte count goes to the additional-data counter
        logic step;     // one multiply step of eight bits
        logic last;     // final step: product goes back to the accumulator
        logic emit;     // move the accumulator to the hash register, clear it
    } ghash_cmd_t;

endpackage

>>> hdl/ghash_req_if.sv
`timescale 1ns / 1ps
// ghash_req_if: request channel carrying one block or a finish
interface ghash_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  valid_bytes;

    modport source (output valid, output req_type, output block_hi, output block_lo,
                    output valid_bytes, input ready);
    modport sink   (input valid, input req_type, input block_hi, input block_lo,
                    input valid_bytes, output ready);
endinterface

>>> hdl/ghash_rsp_if.sv
`timescale 1ns / 1ps
// ghash_rsp_if: result channel carrying the final hash
interface ghash_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_hi;
    logic [63:0] hash_lo;

    modport source (output valid, output hash_hi, output hash_lo, input ready);
    modport sink   (input valid, input hash_hi, input hash_lo, output ready);
endinterface

>>> hdl/ghash_accumulator_unit.sv
`timescale 1ns / 1ps
// ghash_accumulator_unit: top level of the GHASH accumulator
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  req     | in        | valid / ready       | req_type, block_hi, block_lo, valid_bytes
//  rsp     | out       | valid / ready       | hash_hi, hash_lo
//  cfg     | in        | cfg_we, no wait     | cfg_index, cfg_wdata (key halves)
//
//  a block or finish is taken in one transfer, then multiplied: the
//  GF(2^128) multiplier handles eight bits of the accumulator per cycle and
//  the next block needs the finished product, so one item is in flight
//  a finish then moves the product into the result register
//  ignored requests (unused type, zero valid bytes) are accepted and dropped
//  reset clears key, accumulator, byte counters and the control state
//  a held result does not stop block transfers; only a second finish waits
//  for the result register to free up
module ghash_accumulator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ghash_req_if.sink                          req,
    ghash_rsp_if.source                        rsp,
    input  logic                               cfg_we,
    input  logic [ghash_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ghash_pkg::HALF_W-1:0]       cfg_wdata
);
    import ghash_pkg::*;

    // command bundle from the sequencer to the datapath
    ghash_cmd_t cmd;

    // controller: decodes requests, counts multiply steps, owns rsp.valid
    ghash_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .req_type    (req.req_type),
        .valid_bytes (req.valid_bytes),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd)
    );

    // datapath: padding, length block, counters, multiplier, result register
    ghash_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .block_hi    (req.block_hi),
        .block_lo    (req.block_lo),
        .valid_bytes (req.valid_bytes),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .hash_hi     (rsp.hash_hi),
        .hash_lo     (rsp.hash_lo)
    );

endmodule

>>> hdl/ghash_ctrl.sv
`timescale 1ns / 1ps
// ghash_ctrl: request decode, multiply sequencing and result handshake
module ghash_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [ghash_pkg::VBYTES_W-1:0]  valid_bytes,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ghash_pkg::ghash_cmd_t           cmd
);
    import ghash_pkg::*;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(MUL_STEPS - 1);

    ctrl_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic                   fin_reg, fin_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (req_type == REQ_FINISH)
                    begin
                        cmd.load   = 1'b1;
                        cmd.finish = 1'b1;
                        fin_next   = 1'b1;
                        state_next = ST_MUL;
                    end
                    else if ((req_type == REQ_AAD || req_type == REQ_DATA)
                             && valid_bytes != '0)
                    begin
                        cmd.load   = 1'b1;
                        cmd.aad    = (req_type == REQ_AAD);
                        fin_next   = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    cmd.last   = 1'b1;
                    state_next = fin_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

>>> hdl/ghash_dp.sv
`timescale 1ns / 1ps
// ghash_dp: key, accumulator, byte counters and the eight-bit-per-step multiplier
module ghash_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ghash_pkg::ghash_cmd_t              cmd,
    input  logic [ghash_pkg::HALF_W-1:0]       block_hi,
    input  logic [ghash_pkg::HALF_W-1:0]       block_lo,
    input  logic [ghash_pkg::VBYTES_W-1:0]     valid_bytes,
    input  logic                               cfg_we,
    input  logic [ghash_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ghash_pkg::HALF_W-1:0]       cfg_wdata,
    output logic [ghash_pkg::HALF_W-1:0]       hash_hi,
    output logic [ghash_pkg::HALF_W-1:0]       hash_lo
);
    import ghash_pkg::*;

    logic [HALF_W-1:0]   key_hi_reg, key_lo_reg;
    logic [BLOCK_W-1:0]  acc_reg;
    logic [COUNT_W-1:0]  aad_cnt_reg, data_cnt_reg;
    logic [BLOCK_W-1:0]  x_reg, z_reg, v_reg;
    logic [BLOCK_W-1:0]  z_next, v_next;
    logic [BLOCK_W-1:0]  hash_reg;

    logic [VBYTES_W-1:0] nbytes;
    logic [7:0]          mask_shift;
    logic [BLOCK_W-1:0]  byte_mask, padded, len_block, absorb;
    logic [COUNT_W-1:0]  cnt_sel;
    logic [COUNT_W:0]    cnt_sum;
    logic [COUNT_W-1:0]  cnt_sat;

    // clamp to a full block, then keep the leading bytes
    assign nbytes     = (valid_bytes > VBYTES_W'(BLOCK_BYTES))
                        ? VBYTES_W'(BLOCK_BYTES) : valid_bytes;
    assign mask_shift = {nbytes, 3'b000};
    assign byte_mask  = ~({BLOCK_W{1'b1}} >> mask_shift);
    assign padded     = {block_hi, block_lo} & byte_mask;
    assign len_block  = {aad_cnt_reg, 3'b000, data_cnt_reg, 3'b000};
    assign absorb     = acc_reg ^ (cmd.finish ? len_block : padded);

    // saturating byte count
    assign cnt_sel = cmd.aad ? aad_cnt_reg : data_cnt_reg;
    assign cnt_sum = {1'b0, cnt_sel} + (COUNT_W + 1)'(nbytes);
    assign cnt_sat = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];

    // eight bits of x, most significant first, against the shifting key
    always_comb
    begin
        logic [BLOCK_W-1:0] z_t;
        logic [BLOCK_W-1:0] v_t;
        logic               lsb;
        z_t = z_reg;
        v_t = v_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            if (x_reg[BLOCK_W-1-i])
                z_t = z_t ^ v_t;
            lsb = v_t[0];
            v_t = v_t >> 1;
            if (lsb)
                v_t[BLOCK_W-1 -: 8] = v_t[BLOCK_W-1 -: 8] ^ REDUCE_BYTE;
        end
        z_next = z_t;
        v_next = v_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            acc_reg      <= '0;
            aad_cnt_reg  <= '0;
            data_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_KEY_HI)
                key_hi_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_KEY_LO)
                key_lo_reg <= cfg_wdata;

            if (cmd.load)
            begin
                if (cmd.finish)
                begin
                    aad_cnt_reg  <= '0;
                    data_cnt_reg <= '0;
                end
                else if (cmd.aad)
                    aad_cnt_reg <= cnt_sat;
                else
                    data_cnt_reg <= cnt_sat;
            end

            if (cmd.last)
                acc_reg <= z_next;
            else if (cmd.emit)
                acc_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= absorb;
            z_reg <= '0;
            v_reg <= {key_hi_reg, key_lo_reg};
        end
        else if (cmd.step)
        begin
            x_reg <= x_reg << BITS_PER_STEP;
            z_reg <= z_next;
            v_reg <= v_next;
        end
        if (cmd.emit)
            hash_reg <= acc_reg;
    end

    assign hash_hi = hash_reg[BLOCK_W-1:HALF_W];
    assign hash_lo = hash_reg[HALF_W-1:0];

endmodule

>>> tb/ghash_accumulator_unit_tb.sv
`timescale 1ns / 1ps
// ghash_accumulator_unit_tb: self-checking bench for the ghash accumulator with its own GF(2^128) model
module ghash_accumulator_unit_tb;

    import ghash_pkg::*;

    // request code the block must drop without touching its state
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // cycles to let pass after the last hash so a trailing block multiply is done
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 305;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
    } ghash_req_t;

    // tracks hash key, accumulator and byte counts; keeps the hashes still owed
    class ghash_tracker;
        logic [127:0] hash_key;
        logic [127:0] acc;
        logic [60:0]  aad_bytes;
        logic [60:0]  data_bytes;
        logic [127:0] pending_hashes[$];
        int           failures;

        function new();
            hash_key   = '0;
            acc        = '0;
            aad_bytes  = '0;
            data_bytes = '0;
            failures   = 0;
        endfunction

        function void load_key(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
            if (idx == CFG_KEY_HI)
                hash_key[127:64] = val;
            else
                hash_key[63:0] = val;
        endfunction

        // bit-reflected shift-and-add multiply of x by the key
        function logic [127:0] gf128_mul_key(logic [127:0] x);
            logic [127:0] z;
            logic [127:0] v;
            z = '0;
            v = hash_key;
            for (int i = 0; i < 128; i++)
            begin
                if (x[127 - i])
                    z = z ^ v;
                if (v[0])
                    v = (v >> 1) ^ {REDUCE_BYTE, 120'b0};
                else
                    v = v >> 1;
            end
            return z;
        endfunction

        function logic [60:0] add_bytes(logic [60:0] cnt, int n);
            logic [61:0] sum;
            sum = {1'b0, cnt} + 62'(n);
            if (sum > {1'b0, COUNT_MAX})
                return COUNT_MAX;
            return sum[60:0];
        endfunction

        function void absorb_request(ghash_req_t r);
            logic [127:0] blk;
            logic [127:0] mask;
            int           n;
            n = r.nbytes;
            if (r.rtype == REQ_FINISH)
            begin
                acc = gf128_mul_key(acc ^ {aad_bytes, 3'b000, data_bytes, 3'b000});
                pending_hashes.push_back(acc);
                acc        = '0;
                aad_bytes  = '0;
                data_bytes = '0;
                return;
            end
            if (r.rtype == REQ_UNUSED || n == 0)
                return;
            if (n > BLOCK_BYTES)
                n = BLOCK_BYTES;
            mask = ~128'b0 << (8 * (BLOCK_BYTES - n));
            blk  = {r.hi, r.lo} & mask;
            acc  = gf128_mul_key(acc ^ blk);
            if (r.rtype == REQ_AAD)
                aad_bytes = add_bytes(aad_bytes, n);
            else
                data_bytes = add_bytes(data_bytes, n);
        endfunction

        function void check_hash(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (pending_hashes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected hash transfer: %h_%h", hi, lo);
                return;
            end
            want = pending_hashes.pop_front();
            if (hi !== want[127:64] || lo !== want[63:0])
            begin
                failures++;
                if (failures <= 10)
                    $display("hash mismatch: expected hi %h lo %h, got hi %h lo %h",
                             want[127:64], want[63:0], hi, lo);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [HALF_W-1:0]      cfg_wdata;

    ghash_req_if req_ch ();
    ghash_rsp_if rsp_ch ();

    ghash_accumulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ghash_tracker sb = new();

    // idling knobs, changed per phase by the main sequence
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_cycles  = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hard limit well above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("ghash_accumulator_unit_tb NOT OK");
        $finish;
    end

    // receiver: checks every hash transfer, then picks ready for the next edge
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_hash(rsp_ch.hash_hi, rsp_ch.hash_lo);
            if (hold_cycles > 0)
            begin
                // block keeps taking requests until a second finish backs up
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [63:0] random_half();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // block with random payload; valid bytes mostly in range, some zero or past sixteen
    function automatic ghash_req_t random_block(logic [1:0] t);
        ghash_req_t r;
        int         pick;
        r.rtype = t;
        r.hi    = random_half();
        r.lo    = random_half();
        pick    = $urandom_range(99);
        if (pick < 4)
            r.nbytes = 5'd0;
        else if (pick < 9)
            r.nbytes = 5'($urandom_range(31, 17));
        else if (pick < 30)
            r.nbytes = 5'd16;
        else
            r.nbytes = 5'($urandom_range(16, 1));
        return r;
    endfunction

    // one request transfer, with random idle cycles ahead of it
    task automatic send_request(ghash_req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.rtype;
        req_ch.block_hi    <= r.hi;
        req_ch.block_lo    <= r.lo;
        req_ch.valid_bytes <= r.nbytes;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.absorb_request(r);
    endtask

    task automatic offer(logic [1:0] t, logic [63:0] hi, logic [63:0] lo, logic [4:0] nb);
        ghash_req_t r;
        r = '{rtype: t, hi: hi, lo: lo, nbytes: nb};
        send_request(r);
    endtask

    // wait for every owed hash, then let a trailing block multiply finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both key halves; only called with the block idle
    task automatic write_key(logic [63:0] hi, logic [63:0] lo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY_HI;
        cfg_wdata <= hi;
        @(posedge clk);
        sb.load_key(CFG_KEY_HI, hi);
        cfg_index <= CFG_KEY_LO;
        cfg_wdata <= lo;
        @(posedge clk);
        sb.load_key(CFG_KEY_LO, lo);
        cfg_we <= 1'b0;
    endtask

    // messages: a few aad blocks, then data blocks, then a finish; some noise
    // and out-of-order sections mixed in
    task automatic run_traffic(int n_items);
        ghash_req_t r;
        int         counted;
        int         blocks;
        int         aad_split;
        logic [1:0] t;
        counted = 0;
        while (counted < n_items)
        begin
            blocks    = $urandom_range(6);
            aad_split = $urandom_range(blocks);
            for (int b = 0; b < blocks; b++)
            begin
                if ($urandom_range(99) < 8)
                    send_request(random_block(REQ_UNUSED));
                if ($urandom_range(99) < 15)
                    t = $urandom_range(1) ? REQ_DATA : REQ_AAD;
                else
                    t = (b < aad_split) ? REQ_AAD : REQ_DATA;
                r = random_block(t);
                send_request(r);
                if (r.nbytes != 0)
                    counted++;
            end
            r       = random_block(REQ_FINISH);
            r.rtype = REQ_FINISH;
            send_request(r);
            counted++;
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_KEY_HI;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_AAD;
        req_ch.block_hi    <= '0;
        req_ch.block_lo    <= '0;
        req_ch.valid_bytes <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part: sender idles lightly, receiver stalls often
        tx_idle_pct  = 16;
        rx_stall_pct = 67;

        // zero key out of reset: a bare finish hashes to zero
        offer(REQ_FINISH, '0, '0, 5'd0);
        settle();
        write_key({$urandom, $urandom}, {$urandom, $urandom});

        // finish with no blocks still absorbs the all-zero length block
        offer(REQ_FINISH, '1, '1, 5'd0);
        offer(REQ_AAD, '1, '1, 5'd16);
        offer(REQ_AAD, random_half(), random_half(), 5'd1);
        offer(REQ_DATA, random_half(), random_half(), 5'd8);
        offer(REQ_DATA, random_half(), random_half(), 5'd9);
        offer(REQ_DATA, '0, '0, 5'd15);
        // zero valid bytes: dropped, counts untouched
        offer(REQ_AAD, '1, '1, 5'd0);
        // byte counts past sixteen clamp to a full block
        offer(REQ_DATA, random_half(), random_half(), 5'd31);
        offer(REQ_DATA, random_half(), random_half(), 5'd17);
        // unused request code: no effect at all
        offer(REQ_UNUSED, '1, '1, 5'd16);
        offer(REQ_FINISH, random_half(), random_half(), 5'd31);
        // data before aad, sections interleaved
        offer(REQ_DATA, '1, '1, 5'd16);
        offer(REQ_AAD, random_half(), random_half(), 5'd12);
        offer(REQ_DATA, random_half(), random_half(), 5'd5);
        offer(REQ_FINISH, '0, '0, 5'd16);
        // back-to-back finishes
        offer(REQ_FINISH, '0, '0, 5'd0);
        offer(REQ_AAD, random_half(), random_half(), 5'd16);
        offer(REQ_FINISH, '0, '0, 5'd1);
        settle();

        // all-ones key, same idling
        write_key('1, '1);
        run_traffic(PHASE_ITEMS);
        settle();

        // key 0x80.. is the multiplicative identity; idling swapped
        tx_idle_pct  = 67;
        rx_stall_pct = 16;
        write_key(64'h8000_0000_0000_0000, '0);
        run_traffic(PHASE_ITEMS);
        settle();

        // random key, no idling on either side
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        run_traffic(PHASE_ITEMS);
        settle();

        // receiver holds off for a long stretch while requests keep coming,
        // so a second finish backs up and stalls the request channel
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        hold_cycles  = LONG_HOLD;
        run_traffic(PHASE_ITEMS);
        settle();

        if (sb.failures == 0 && sb.pending_hashes.size() == 0)
            $display("ghash_accumulator_unit_tb OK");
        else
            $display("ghash_accumulator_unit_tb NOT OK");
        $finish;
    end

endmodule
